[rtl/core/fci_pkg.sv]
// ----------------------------------------------------------------------------
// fci_pkg
// Command codes, status bits and pending command type of the flash
// command interface.
// ----------------------------------------------------------------------------
package fci_pkg;

   localparam logic [7:0] CMD_ERASE_SETUP   = 8'h20;
   localparam logic [7:0] CMD_ERASE_CONFIRM = 8'hd0;
   localparam logic [7:0] CMD_PROGRAM       = 8'h40;
   localparam logic [7:0] CMD_CLEAR_STATUS  = 8'h50;
   localparam logic [7:0] CMD_READ_STATUS   = 8'h70;
   localparam logic [7:0] CMD_READ_ARRAY    = 8'hff;

   localparam logic [7:0] STAT_READY       = 8'h80;
   localparam logic [7:0] STAT_ERASE_ERR   = 8'h20;
   localparam logic [7:0] STAT_PROGRAM_ERR = 8'h10;

   localparam logic [7:0] ERASED_BYTE = 8'hff;

   typedef enum logic [1:0] {
      PEND_NONE    = 2'd0,
      PEND_ERASE   = 2'd1,
      PEND_PROGRAM = 2'd2
   } pend_type;

endpackage

[rtl/core/fci_ram.sv]
// ----------------------------------------------------------------------------
// fci_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fci_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/flash_command_interface_unit.sv]
// ----------------------------------------------------------------------------
// flash_command_interface_unit
// Two-bank flash array with a byte command interface on a bus.
// ----------------------------------------------------------------------------
// An access is accepted in S_IDLE, then S_REDUCE subtracts ARRAY_BYTES from
// the offset until it lies inside the array. Each array byte read or
// programmed passes through S_BYTE and then S_RDWAIT or S_PGWAIT, since the
// single port of the array RAM has registered read data; a status byte or a
// plain command byte needs only S_BYTE. S_FINISH then presents the result.
// An erase confirm steps through the banks in S_EFIND to locate the bank and
// then sweeps it in S_SWEEP (cut short where the array end falls inside the
// bank). After reset a clearing pass fills the array with 0xff before the
// first request is taken.
module flash_command_interface_unit #(
   parameter int ARRAY_BYTES = 16384,
   parameter int BANK_BYTES  = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [13:0] req_byte_offset,
   input  logic [2:0]  req_access_size,
   input  logic [31:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [7:0]  rsp_status_byte
);

   import fci_pkg::*;

   localparam int AW = $clog2(ARRAY_BYTES);
   localparam int RW = ((AW > 14) ? AW : 14) + 1;
   localparam logic [RW-1:0] ARRAY_R = RW'(ARRAY_BYTES);
   localparam logic [RW-1:0] BANK_R  = RW'(BANK_BYTES);
   localparam logic [RW-1:0] ONE_R   = RW'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_BYTE,
      S_RDWAIT,
      S_PGWAIT,
      S_EFIND,
      S_SWEEP,
      S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic             op_ff, op_in;
   logic [2:0]       size_ff, size_in;
   logic [31:0]      value_ff, value_in;
   logic [RW-1:0]    addr_ff, addr_in;
   logic [1:0]       idx_ff, idx_in;
   logic [31:0]      data_ff, data_in;
   logic             mode_ff, mode_in;
   logic [7:0]       status_ff, status_in;
   pend_type         pend_ff, pend_in;
   logic [AW-1:0]    start_ff, start_in;
   logic [AW-1:0]    sweep_ff, sweep_in;
   logic [AW-1:0]    end_ff, end_in;
   logic             erasing_ff, erasing_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;
   logic [7:0]       rsp_status_ff, rsp_status_in;

   logic             ram_we;
   logic [AW-1:0]    ram_addr;
   logic [7:0]       ram_wdata;
   logic [7:0]       ram_rdata;

   logic [1:0]       sel;
   logic [7:0]       cur_byte;
   logic             last;
   logic             do_adv;
   logic [RW-1:0]    bank_next;
   logic [RW-1:0]    bank_last;

   fci_ram #(
      .WIDTH (8),
      .DEPTH (ARRAY_BYTES)
   ) u_array (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign sel       = 2'(size_ff - 3'd1 - {1'b0, idx_ff});
   assign cur_byte  = value_ff[8*sel +: 8];
   assign last      = ({1'b0, idx_ff} == 3'(size_ff - 3'd1));
   assign bank_next = RW'(start_ff) + BANK_R;
   assign bank_last = bank_next - ONE_R;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      value_in      = value_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      data_in       = data_ff;
      mode_in       = mode_ff;
      status_in     = status_ff;
      pend_in       = pend_ff;
      start_in      = start_ff;
      sweep_in      = sweep_ff;
      end_in        = end_ff;
      erasing_in    = erasing_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_addr      = addr_ff[AW-1:0];
      ram_wdata     = ERASED_BYTE;
      do_adv        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               size_in  = (req_access_size > 3'd4) ? 3'd4 : req_access_size;
               value_in = req_write_value;
               addr_in  = RW'(req_byte_offset);
               idx_in   = 2'd0;
               data_in  = 32'd0;
               state_in = (req_access_size == 3'd0) ? S_FINISH : S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (addr_ff >= ARRAY_R) begin
               addr_in = addr_ff - ARRAY_R;
            end else begin
               state_in = S_BYTE;
            end
         end
         S_BYTE: begin
            if (!op_ff) begin
               if (mode_ff) begin
                  data_in = {data_ff[23:0], status_ff};
                  do_adv  = 1'b1;
               end else begin
                  state_in = S_RDWAIT;
               end
            end else begin
               case (pend_ff)
                  PEND_PROGRAM: begin
                     state_in = S_PGWAIT;
                  end
                  PEND_ERASE: begin
                     pend_in = PEND_NONE;
                     mode_in = 1'b1;
                     if (cur_byte == CMD_ERASE_CONFIRM) begin
                        start_in = '0;
                        state_in = S_EFIND;
                     end else begin
                        status_in = status_ff | STAT_ERASE_ERR | STAT_PROGRAM_ERR;
                        do_adv    = 1'b1;
                     end
                  end
                  default: begin
                     do_adv = 1'b1;
                     case (cur_byte)
                        CMD_ERASE_SETUP: begin
                           pend_in = PEND_ERASE;
                           mode_in = 1'b1;
                        end
                        CMD_PROGRAM: begin
                           pend_in = PEND_PROGRAM;
                           mode_in = 1'b1;
                        end
                        CMD_CLEAR_STATUS: begin
                           status_in = STAT_READY;
                           mode_in   = 1'b1;
                        end
                        CMD_READ_STATUS: begin
                           mode_in = 1'b1;
                        end
                        CMD_READ_ARRAY: begin
                           mode_in = 1'b0;
                        end
                        default: begin
                        end
                     endcase
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            data_in = {data_ff[23:0], ram_rdata};
            do_adv  = 1'b1;
         end
         S_PGWAIT: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & cur_byte;
            pend_in   = PEND_NONE;
            mode_in   = 1'b1;
            do_adv    = 1'b1;
         end
         S_EFIND: begin
            if (bank_next <= addr_ff) begin
               start_in = AW'(bank_next);
            end else begin
               sweep_in   = start_ff;
               end_in     = (bank_last < ARRAY_R - ONE_R) ? AW'(bank_last)
                                                          : AW'(ARRAY_R - ONE_R);
               erasing_in = 1'b1;
               state_in   = S_SWEEP;
            end
         end
         S_SWEEP: begin
            ram_we    = 1'b1;
            ram_addr  = sweep_ff;
            ram_wdata = ERASED_BYTE;
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff == end_ff) begin
               if (erasing_ff) begin
                  do_adv = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = op_ff ? 32'd0 : data_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_adv) begin
         addr_in  = (addr_ff == ARRAY_R - ONE_R) ? '0 : addr_ff + ONE_R;
         idx_in   = idx_ff + 2'd1;
         state_in = last ? S_FINISH : S_BYTE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         mode_ff      <= 1'b0;
         status_ff    <= STAT_READY;
         pend_ff      <= PEND_NONE;
         sweep_ff     <= '0;
         end_ff       <= AW'(ARRAY_R - ONE_R);
         erasing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         status_ff    <= status_in;
         pend_ff      <= pend_in;
         sweep_ff     <= sweep_in;
         end_ff       <= end_in;
         erasing_ff   <= erasing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      size_ff       <= size_in;
      value_ff      <= value_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      data_ff       <= data_in;
      start_ff      <= start_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_status_byte = rsp_status_ff;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Exercises flash_command_interface_unit through its request and response
// channels. A byte-level image of the flash array, the status register, the
// status view and the pending command is kept alongside the block. Each
// accepted request updates that image and queues the reply it must produce,
// and every reply taken from the block is compared against it. Directed
// accesses cover erased reads, wrapping, odd sizes, programming, bank erase,
// bad confirms and the status commands. Random command sequences, random
// idle gaps on both sides and a long response stall follow.
// ----------------------------------------------------------------------------
module testbench;
   import fci_pkg::*;

   localparam int ARRAY_BYTES    = 16384;
   localparam int BANK_BYTES     = 8192;
   localparam int ITEM_TARGET    = 1650;
   localparam int LONG_HOLD      = 250;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic [31:0] read_data;
      logic [7:0]  status_byte;
   } flash_reply_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_operation;
   logic [13:0] req_byte_offset;
   logic [2:0]  req_access_size;
   logic [31:0] req_write_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic [7:0]  rsp_status_byte;

   logic [7:0]      flash_image [ARRAY_BYTES];
   logic            status_view;
   logic [7:0]      status_now;
   pend_type        pend_now;
   flash_reply_type flash_replies [$];

   bit sender_quiet;
   bit receiver_quiet;
   bit rsp_hold_request;
   int items_sent;
   int replies_checked;
   int mismatch_count;
   int idle_cycles;
   int reads_seen;
   int writes_seen;
   int status_reads;
   int banks_erased;
   int bytes_programmed;
   int erase_errors;

   flash_command_interface_unit #(
      .ARRAY_BYTES(ARRAY_BYTES),
      .BANK_BYTES (BANK_BYTES)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_byte_offset(req_byte_offset),
      .req_access_size(req_access_size),
      .req_write_value(req_write_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_status_byte(rsp_status_byte)
   );

   always #4 clock = ~clock;

   function automatic int draw_wait(input bit quiet);
      return quiet ? 0 : int'($urandom_range(0, 18));
   endfunction

   function automatic logic [13:0] pick_offset();
      case ($urandom_range(0, 4))
         0: return 14'($urandom_range(0, 31));
         1: return 14'(BANK_BYTES - 16 + $urandom_range(0, 31));
         2: return 14'(ARRAY_BYTES - 16 + $urandom_range(0, 15));
         default: return 14'($urandom());
      endcase
   endfunction

   function automatic void run_command_byte(input int unsigned addr, input logic [7:0] cmd);
      int unsigned start;
      int unsigned stop;
      if (pend_now == PEND_PROGRAM) begin
         flash_image[addr] = flash_image[addr] & cmd;
         pend_now = PEND_NONE;
         status_view = 1'b1;
         bytes_programmed++;
      end else if (pend_now == PEND_ERASE) begin
         pend_now = PEND_NONE;
         status_view = 1'b1;
         if (cmd == CMD_ERASE_CONFIRM) begin
            start = (addr / BANK_BYTES) * BANK_BYTES;
            stop = start + BANK_BYTES;
            if (stop > ARRAY_BYTES)
               stop = ARRAY_BYTES;
            for (int unsigned a = start; a < stop; a++)
               flash_image[a] = ERASED_BYTE;
            banks_erased++;
         end else begin
            status_now = status_now | STAT_ERASE_ERR | STAT_PROGRAM_ERR;
            erase_errors++;
         end
      end else begin
         case (cmd)
            CMD_ERASE_SETUP: begin
               pend_now = PEND_ERASE;
               status_view = 1'b1;
            end
            CMD_PROGRAM: begin
               pend_now = PEND_PROGRAM;
               status_view = 1'b1;
            end
            CMD_CLEAR_STATUS: begin
               status_now = STAT_READY;
               status_view = 1'b1;
            end
            CMD_READ_STATUS: status_view = 1'b1;
            CMD_READ_ARRAY: status_view = 1'b0;
            default: ;
         endcase
      end
   endfunction

   function automatic flash_reply_type flash_access(input logic op,
                                                    input logic [13:0] offset,
                                                    input logic [2:0] size,
                                                    input logic [31:0] value);
      flash_reply_type reply;
      int unsigned     count;
      int unsigned     addr;
      count = (size > 3'd4) ? 4 : size;
      reply.read_data = '0;
      for (int unsigned i = 0; i < count; i++) begin
         addr = (offset + i) % ARRAY_BYTES;
         if (op == 1'b0) begin
            if (status_view)
               status_reads++;
            reply.read_data = {reply.read_data[23:0],
                               status_view ? status_now : flash_image[addr]};
         end else begin
            run_command_byte(addr, value[8 * (count - 1 - i) +: 8]);
         end
      end
      if (op == 1'b0)
         reads_seen++;
      else
         writes_seen++;
      reply.status_byte = status_now;
      return reply;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("MISMATCH %s at reply %0d: got %h, want %h", what, replies_checked, got,
               want);
   endtask

   // one request transfer; valid stays up on return so a zero gap keeps it high
   task automatic send_transfer(input logic op, input logic [13:0] offset,
                                input logic [2:0] size, input logic [31:0] value);
      int gap;
      if ($urandom_range(0, 39) == 0)
         sender_quiet = !sender_quiet;
      gap = draw_wait(sender_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation = op;
      req_byte_offset = offset;
      req_access_size = size;
      req_write_value = value;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      flash_replies.push_back(flash_access(op, offset, size, value));
      items_sent++;
   endtask

   task automatic write_bytes(input logic [13:0] offset, input logic [2:0] size,
                              input logic [31:0] value);
      send_transfer(1'b1, offset, size, value);
   endtask

   task automatic read_bytes(input logic [13:0] offset, input logic [2:0] size);
      send_transfer(1'b0, offset, size, $urandom());
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (flash_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_erased_array();
      read_bytes(14'd0, 3'd1);
      read_bytes(14'(ARRAY_BYTES - 2), 3'd4);
      read_bytes(14'd100, 3'd0);
      read_bytes(14'(BANK_BYTES - 2), 3'd7);
      read_bytes(14'(ARRAY_BYTES - 1), 3'd3);
      wait_for_drain();
   endtask

   task automatic test_program();
      write_bytes(14'd99, 3'd2, {16'd0, CMD_PROGRAM, 8'ha5});
      read_bytes(14'd98, 3'd4);
      write_bytes(14'd0, 3'd1, {24'd0, CMD_READ_ARRAY});
      read_bytes(14'd98, 3'd4);
      write_bytes(14'(ARRAY_BYTES - 2), 3'd4, {CMD_PROGRAM, 8'h3c, CMD_PROGRAM, 8'h0f});
      write_bytes(14'h3fff, 3'd1, {24'd0, CMD_READ_ARRAY});
      read_bytes(14'(ARRAY_BYTES - 2), 3'd4);
      write_bytes(14'd0, 3'd0, {24'd0, CMD_PROGRAM});
      write_bytes(14'd200, 3'd6, 32'hffff_ffff);
      read_bytes(14'(ARRAY_BYTES - 1), 3'd5);
      wait_for_drain();
   endtask

   task automatic test_erase_and_status();
      write_bytes(14'(BANK_BYTES - 1), 3'd2, {16'd0, CMD_ERASE_SETUP, CMD_ERASE_CONFIRM});
      read_bytes(14'(BANK_BYTES - 1), 3'd2);
      write_bytes(14'd5, 3'd1, {24'd0, CMD_ERASE_SETUP});
      write_bytes(14'd6, 3'd1, 32'h0000_0011);
      read_bytes(14'd6, 3'd1);
      write_bytes(14'd7, 3'd1, {24'd0, CMD_READ_STATUS});
      write_bytes(14'd7, 3'd1, 32'h0000_0033);
      read_bytes(14'd7, 3'd3);
      write_bytes(14'd8, 3'd1, {24'd0, CMD_CLEAR_STATUS});
      write_bytes(14'd9, 3'd7, 32'h0000_0000);
      write_bytes(14'd9, 3'd1, {24'd0, CMD_READ_ARRAY});
      read_bytes(14'd0, 3'd4);
      write_bytes(14'd0, 3'd2, {16'd0, CMD_ERASE_SETUP, CMD_ERASE_CONFIRM});
      write_bytes(14'd0, 3'd1, {24'd0, CMD_READ_ARRAY});
      read_bytes(14'(ARRAY_BYTES - 2), 3'd4);
      wait_for_drain();
   endtask

   // stall the response side while requests keep coming
   task automatic test_backpressure();
      sender_quiet = 1'b1;
      rsp_hold_request = 1'b1;
      repeat (20) read_bytes(pick_offset(), 3'($urandom_range(1, 4)));
      sender_quiet = 1'b0;
      wait_for_drain();
   endtask

   task automatic test_random_traffic();
      logic [13:0] at;
      logic [7:0]  data_a;
      logic [7:0]  data_b;
      logic [7:0]  cmd;
      int unsigned pick;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         at = pick_offset();
         data_a = 8'($urandom());
         data_b = 8'($urandom());
         if (pick < 30) begin
            case ($urandom_range(0, 2))
               0: begin
                  write_bytes(pick_offset(), 3'd1, {24'd0, CMD_PROGRAM});
                  write_bytes(at, 3'd1, {24'd0, data_a});
               end
               1: write_bytes(at - 14'd1, 3'd2, {16'd0, CMD_PROGRAM, data_a});
               default: begin
                  write_bytes(at - 14'd1, 3'd4, {CMD_PROGRAM, data_a, CMD_PROGRAM, data_b});
               end
            endcase
            if ($urandom_range(0, 3) != 0)
               write_bytes(pick_offset(), 3'd1, {24'd0, CMD_READ_ARRAY});
            read_bytes(at - 14'($urandom_range(0, 3)), 3'($urandom_range(1, 4)));
         end else if (pick < 32) begin
            cmd = ($urandom_range(0, 4) == 0) ? data_b : CMD_ERASE_CONFIRM;
            if ($urandom_range(0, 1) == 0) begin
               write_bytes(pick_offset(), 3'd1, {24'd0, CMD_ERASE_SETUP});
               write_bytes(at, 3'd1, {24'd0, cmd});
            end else begin
               write_bytes(at, 3'd2, {16'd0, CMD_ERASE_SETUP, cmd});
            end
            read_bytes(at, 3'($urandom_range(1, 4)));
         end else if (pick < 45) begin
            case ($urandom_range(0, 2))
               0: cmd = CMD_CLEAR_STATUS;
               1: cmd = CMD_READ_STATUS;
               default: cmd = CMD_READ_ARRAY;
            endcase
            write_bytes(pick_offset(), 3'd1, {24'd0, cmd});
            read_bytes(at, 3'($urandom_range(0, 7)));
         end else if (pick < 80) begin
            read_bytes(at, 3'($urandom_range(0, 7)));
         end else begin
            write_bytes(at, 3'($urandom_range(0, 7)), $urandom());
         end
         if (pick == 99 && $urandom_range(0, 2) == 0)
            wait_for_drain();
      end
      wait_for_drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = 1'b0;
      req_byte_offset = '0;
      req_access_size = '0;
      req_write_value = '0;
      for (int a = 0; a < ARRAY_BYTES; a++)
         flash_image[a] = ERASED_BYTE;
      status_view = 1'b0;
      status_now = STAT_READY;
      pend_now = PEND_NONE;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_erased_array();
      test_program();
      test_erase_and_status();
      test_backpressure();
      test_random_traffic();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d requests: %0d reads (%0d status bytes), %0d writes",
               items_sent, reads_seen, status_reads, writes_seen);
      $display("Erased %0d banks, programmed %0d bytes, %0d bad erase confirms",
               banks_erased, bytes_programmed, erase_errors);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // response side: random ready gaps, plus one long hold on request
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 39) == 0)
            receiver_quiet = !receiver_quiet;
         gap = draw_wait(receiver_quiet);
         if (rsp_hold_request) begin
            gap = LONG_HOLD;
            rsp_hold_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      flash_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         replies_checked++;
         if (flash_replies.size() == 0) begin
            report_mismatch("unexpected reply", rsp_read_data, 32'd0);
         end else begin
            want = flash_replies.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_status_byte !== want.status_byte)
               report_mismatch("status_byte", {24'd0, rsp_status_byte},
                               {24'd0, want.status_byte});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
